/* rtl/core/cwe_pkg.sv */
// Shared types and constants for the sliding-window contrast-limited equaliser.
// Used by the top level, the divider and the generic RAM instances; no dependencies.
`default_nettype none

package cwe_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int MaxWindow = 63;
  localparam int MaxBins   = 256;
  localparam int Channels  = 4;

  localparam int StoreDepth = MaxWidth * MaxHeight * Channels;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int SampleW    = 8;
  localparam int HistDepth  = 256;
  localparam int CountW     = 12;

  localparam int NumW  = 48;
  localparam int QuotW = 9;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN,
    ST_WALK,
    ST_TAIL,
    ST_MUL,
    ST_SUM,
    ST_NUM,
    ST_DIVGO,
    ST_DIV
  } state_e;

  typedef enum logic [2:0] {
    CFG_BIN_COUNT    = 3'd0,
    CFG_CLIP_LEVEL   = 3'd1,
    CFG_WINDOW_SIZE  = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

endpackage

`default_nettype wire

/* rtl/core/cwe_ram.sv */
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
`default_nettype none

module cwe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int Aw   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/cwe_div.sv */
// Restoring divider, one quotient bit per cycle, for the final scaling step.
// Depends on cwe_pkg for the operand and quotient widths.
`default_nettype none

module cwe_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [cwe_pkg::NumW-1:0] num_i,
  input  wire logic [cwe_pkg::NumW-1:0] den_i,
  output logic                          done_o,
  output logic [cwe_pkg::QuotW-1:0]     quot_o
);

  localparam int CntW = $clog2(cwe_pkg::QuotW);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [cwe_pkg::NumW-1:0]   rem_q, rem_d;
  logic [cwe_pkg::NumW-1:0]   dsh_q, dsh_d;
  logic [cwe_pkg::QuotW-1:0]  quot_q, quot_d;
  logic                       fits;

  assign fits = rem_q >= dsh_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CntW'(cwe_pkg::QuotW - 1);
      rem_d  = num_i;
      dsh_d  = den_i << (cwe_pkg::QuotW - 1);
      quot_d = '0;
    end else if (run_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[cwe_pkg::QuotW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/core/clahe_window_equalizer.sv */
// Top level of the sliding-window contrast-limited equaliser: frame store, value
// histogram, bin walk and final scaling. Depends on cwe_pkg, cwe_ram and cwe_div.
//
// A store item (req_type 0) writes one sample into the frame store in the cycle it is
// accepted and leaves busy low. A query item (req_type 1) raises busy and returns one
// result on equalized_value_o with a one-cycle out_valid_o strobe; the receiver cannot
// stall, so take it in that cycle. A query makes one frame store read per window pixel
// through the histogram read-modify-write pipeline, a 256-entry walk of the value
// histogram, which also clears it, and a run of the divider. With window size below 16
// the bin size search may dominate instead of the window scan. After reset the block is
// busy while the histogram memory is cleared; configuration writes are taken at any
// time but should only be made while busy is low.
`default_nettype none

module clahe_window_equalizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  column_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [1:0]  channel_i,
  input  wire logic [7:0]  pixel_value_i,
  output logic             out_valid_o,
  output logic [7:0]       equalized_value_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_wdata_i
);

  localparam int HistAw = $clog2(cwe_pkg::HistDepth);

  cwe_pkg::state_e state_q, state_d;

  // configuration
  logic [8:0]  bin_count_q;
  logic [16:0] clip_q;
  logic [5:0]  ws_q;
  logic [8:0]  iw_q;
  logic [8:0]  ih_q;
  logic [8:0]  nb;
  logic [5:0]  ws;
  logic [8:0]  img_w;
  logic [8:0]  img_h;
  logic [4:0]  half;

  // query
  logic [7:0]  col_q;
  logic [7:0]  row_q;
  logic [1:0]  ch_q;
  logic [7:0]  cv_q;
  logic [11:0] n_q;
  logic [28:0] lim_q;
  logic [5:0]  dx_q;
  logic [5:0]  dy_q;
  logic [7:0]  clr_q;

  // bin size search
  logic [8:0]  bs_q;
  logic [9:0]  bs_acc_q;
  logic        bs_done_q;

  // histogram pipeline
  logic        p1_v_q, p1_cen_q, p1_inb_q;
  logic        p2_v_q;
  logic [7:0]  p2_val_q;
  logic        wr_v_q;
  logic [7:0]  wr_addr_q;
  logic [cwe_pkg::CountW-1:0] wr_data_q;

  // bin walk
  logic [7:0]  walk_cnt_q;
  logic        wv_q;
  logic [7:0]  wu_q;
  logic [cwe_pkg::CountW-1:0] acc_q;
  logic [8:0]  sub_q;
  logic [7:0]  bin_q;
  logic [8:0]  bstart_q;
  logic [7:0]  cb_q;
  logic [28:0] excess_q;
  logic [28:0] sum_q;

  // final arithmetic
  logic [37:0] m1_q, m2_q;
  logic [20:0] m3_q;
  logic [38:0] s_q;
  logic [cwe_pkg::NumW-1:0] num_q, den_q;
  logic        out_valid_q;
  logic [7:0]  result_q;

  logic        accept, query_acc, store_acc;
  logic [9:0]  sx, sy;
  logic        scan_inb, cen_inb;
  logic        scan_last;
  logic [cwe_pkg::StoreAw-1:0] fs_raddr, fs_waddr;
  logic [cwe_pkg::SampleW-1:0] fs_rdata;
  logic [7:0]  v1;
  logic        h_we;
  logic [HistAw-1:0] h_waddr, h_raddr;
  logic [cwe_pkg::CountW-1:0] h_wdata, h_rdata, base;
  logic [cwe_pkg::CountW-1:0] tot;
  logic        last_in_bin;
  logic [28:0] a_val, part;
  logic        div_start, div_done;
  logic [cwe_pkg::QuotW-1:0] quot;

  // saturate registers into range
  always_comb begin
    nb = bin_count_q;
    if (bin_count_q == '0) nb = 9'd1;
    else if (bin_count_q > 9'(cwe_pkg::MaxBins)) nb = 9'(cwe_pkg::MaxBins);
    ws = (ws_q == '0) ? 6'd1 : ws_q;
    img_w = iw_q;
    if (iw_q == '0) img_w = 9'd1;
    else if (iw_q > 9'(cwe_pkg::MaxWidth)) img_w = 9'(cwe_pkg::MaxWidth);
    img_h = ih_q;
    if (ih_q == '0) img_h = 9'd1;
    else if (ih_q > 9'(cwe_pkg::MaxHeight)) img_h = 9'(cwe_pkg::MaxHeight);
  end

  assign half      = ws[5:1];
  assign accept    = start && !busy;
  assign query_acc = accept && (req_type_i == cwe_pkg::REQ_QUERY);
  assign store_acc = accept && (req_type_i == cwe_pkg::REQ_STORE);

  assign sx = {2'b00, col_q} + {4'b0000, dx_q} - {5'b00000, half};
  assign sy = {2'b00, row_q} + {4'b0000, dy_q} - {5'b00000, half};
  assign scan_inb = !sx[9] && (sx < {1'b0, img_w}) && !sy[9] && (sy < {1'b0, img_h});
  assign cen_inb  = ({1'b0, col_q} < img_w) && ({1'b0, row_q} < img_h);
  assign scan_last = (dx_q == ws - 6'd1) && (dy_q == ws - 6'd1);

  assign fs_raddr = (state_q == cwe_pkg::ST_CENTER) ? {row_q, col_q, ch_q}
                                                    : {sy[7:0], sx[7:0], ch_q};
  assign fs_waddr = {row_i, column_i, channel_i};

  cwe_ram #(
    .Width(cwe_pkg::SampleW),
    .Depth(cwe_pkg::StoreDepth)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (store_acc),
    .waddr_i(fs_waddr),
    .wdata_i(pixel_value_i),
    .raddr_i(fs_raddr),
    .rdata_o(fs_rdata)
  );

  assign v1 = p1_inb_q ? fs_rdata : 8'd0;

  // forward the write made at the last edge, which the read-first RAM missed
  assign base = (wr_v_q && (wr_addr_q == p2_val_q)) ? wr_data_q : h_rdata;

  always_comb begin
    h_we    = 1'b0;
    h_waddr = p2_val_q;
    h_wdata = base + 1'b1;
    h_raddr = v1;
    case (state_q)
      cwe_pkg::ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
      end
      cwe_pkg::ST_WALK: begin
        h_we    = 1'b1;
        h_waddr = walk_cnt_q;
        h_wdata = '0;
        h_raddr = walk_cnt_q;
      end
      default: begin
        h_we = p2_v_q;
      end
    endcase
  end

  cwe_ram #(
    .Width(cwe_pkg::CountW),
    .Depth(cwe_pkg::HistDepth)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  // bin walk: values arrive in order, bins close when their span is used up
  assign tot         = acc_q + h_rdata;
  assign last_in_bin = (wu_q == 8'd255) ||
                       ((sub_q == bs_q - 9'd1) && ({1'b0, bin_q} != nb - 9'd1));
  assign a_val       = {1'b0, tot, 16'h0000};
  assign part        = (a_val > lim_q) ? lim_q : a_val;

  assign div_start = (state_q == cwe_pkg::ST_DIVGO);

  cwe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      cwe_pkg::ST_CLEAR:  if (clr_q == 8'hff) state_d = cwe_pkg::ST_IDLE;
      cwe_pkg::ST_IDLE:   if (query_acc) state_d = cwe_pkg::ST_CENTER;
      cwe_pkg::ST_CENTER: state_d = cwe_pkg::ST_SCAN;
      cwe_pkg::ST_SCAN:   if (scan_last) state_d = cwe_pkg::ST_DRAIN;
      cwe_pkg::ST_DRAIN: begin
        if (!p1_v_q && !p2_v_q && bs_done_q) state_d = cwe_pkg::ST_WALK;
      end
      cwe_pkg::ST_WALK:   if (walk_cnt_q == 8'hff) state_d = cwe_pkg::ST_TAIL;
      cwe_pkg::ST_TAIL:   state_d = cwe_pkg::ST_MUL;
      cwe_pkg::ST_MUL:    state_d = cwe_pkg::ST_SUM;
      cwe_pkg::ST_SUM:    state_d = cwe_pkg::ST_NUM;
      cwe_pkg::ST_NUM:    state_d = cwe_pkg::ST_DIVGO;
      cwe_pkg::ST_DIVGO:  state_d = cwe_pkg::ST_DIV;
      cwe_pkg::ST_DIV:    if (div_done) state_d = cwe_pkg::ST_IDLE;
      default:            state_d = cwe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cwe_pkg::ST_CLEAR;
      bin_count_q <= 9'd256;
      clip_q      <= 17'd65536;
      ws_q        <= 6'd9;
      iw_q        <= 9'd256;
      ih_q        <= 9'd256;
      clr_q       <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      wr_v_q      <= 1'b0;
      wv_q        <= 1'b0;
      bs_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cwe_pkg::CFG_BIN_COUNT:    bin_count_q <= cfg_wdata_i[8:0];
          cwe_pkg::CFG_CLIP_LEVEL:   clip_q      <= cfg_wdata_i;
          cwe_pkg::CFG_WINDOW_SIZE:  ws_q        <= cfg_wdata_i[5:0];
          cwe_pkg::CFG_IMAGE_WIDTH:  iw_q        <= cfg_wdata_i[8:0];
          cwe_pkg::CFG_IMAGE_HEIGHT: ih_q        <= cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      if (state_q == cwe_pkg::ST_CLEAR) clr_q <= clr_q + 8'd1;
      p1_v_q <= (state_q == cwe_pkg::ST_CENTER) || (state_q == cwe_pkg::ST_SCAN);
      p2_v_q <= p1_v_q && !p1_cen_q;
      wr_v_q <= p2_v_q;
      wv_q   <= (state_q == cwe_pkg::ST_WALK);
      if (query_acc) begin
        bs_done_q <= 1'b0;
      end else if (!bs_done_q && bs_acc_q >= 10'd256) begin
        bs_done_q <= 1'b1;
      end
      out_valid_q <= (state_q == cwe_pkg::ST_DIV) && div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      col_q    <= column_i;
      row_q    <= row_i;
      ch_q     <= channel_i;
      dx_q     <= '0;
      dy_q     <= '0;
      bs_q     <= 9'd1;
      bs_acc_q <= {1'b0, nb};
      acc_q    <= '0;
      sub_q    <= '0;
      bin_q    <= '0;
      bstart_q <= '0;
      cb_q     <= '0;
      excess_q <= '0;
      sum_q    <= '0;
    end else begin
      // smallest bin size whose span covers all 256 values
      if (!bs_done_q && bs_acc_q < 10'd256) begin
        bs_q     <= bs_q + 9'd1;
        bs_acc_q <= bs_acc_q + {1'b0, nb};
      end
      if (state_q == cwe_pkg::ST_SCAN) begin
        if (dx_q == ws - 6'd1) begin
          dx_q <= '0;
          dy_q <= dy_q + 6'd1;
        end else begin
          dx_q <= dx_q + 6'd1;
        end
      end
      if (wv_q) begin
        if (wu_q == cv_q) cb_q <= bin_q;
        if (last_in_bin) begin
          if (a_val > lim_q) excess_q <= excess_q + (a_val - lim_q);
          if ({1'b0, cv_q} >= bstart_q) sum_q <= sum_q + part;
          acc_q    <= '0;
          sub_q    <= '0;
          bin_q    <= bin_q + 8'd1;
          bstart_q <= {1'b0, wu_q} + 9'd1;
        end else begin
          acc_q <= tot;
          sub_q <= sub_q + 9'd1;
        end
      end
    end
    if (state_q == cwe_pkg::ST_CENTER) n_q <= 12'(ws * ws);
    if (state_q == cwe_pkg::ST_SCAN) lim_q <= 29'(clip_q * n_q);
    p1_cen_q <= (state_q == cwe_pkg::ST_CENTER);
    p1_inb_q <= (state_q == cwe_pkg::ST_CENTER) ? cen_inb : scan_inb;
    if (p1_v_q && p1_cen_q) cv_q <= v1;
    p2_val_q  <= v1;
    wr_addr_q <= p2_val_q;
    wr_data_q <= base + 1'b1;
    walk_cnt_q <= (state_q == cwe_pkg::ST_WALK) ? walk_cnt_q + 8'd1 : 8'd0;
    wu_q       <= walk_cnt_q;
    if (state_q == cwe_pkg::ST_MUL) begin
      m1_q <= 38'(nb * sum_q);
      m2_q <= 38'(({1'b0, cb_q} + 9'd1) * excess_q);
      m3_q <= 21'(nb * n_q);
    end
    if (state_q == cwe_pkg::ST_SUM) s_q <= {1'b0, m1_q} + {1'b0, m2_q};
    if (state_q == cwe_pkg::ST_NUM) begin
      // 510 * s, plus half the denominator for rounding
      num_q <= (cwe_pkg::NumW'(s_q) << 9) - (cwe_pkg::NumW'(s_q) << 1)
             + (cwe_pkg::NumW'(m3_q) << 16);
      den_q <= cwe_pkg::NumW'(m3_q) << 17;
    end
    if (div_done) result_q <= (quot > 9'd255) ? 8'd255 : quot[7:0];
  end

  assign busy              = (state_q != cwe_pkg::ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign equalized_value_o = result_q;

  a_out_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> busy)
    else $error("query accepted without raising busy");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cwe_pkg::ST_SCAN) |-> (dx_q < ws && dy_q < ws))
    else $error("window scan counter out of range");

  a_walk_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cwe_pkg::ST_WALK) |-> (!p1_v_q && !p2_v_q))
    else $error("histogram update still in flight during walk");

  a_walk_bin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> ({1'b0, bin_q} < nb))
    else $error("bin index beyond bin count");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for clahe_window_equalizer: a directed table, then random phases.
// Depends on cwe_pkg and the RTL. An in-bench predictor of the windowed equalisation
// produces the expected values unless a directed row gives its own.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CfgSpare = 3'd5;  // index beyond the register list

  typedef enum int { ACT_STORE, ACT_QUERY, ACT_CFG } act_e;
  typedef struct {
    act_e        act;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [1:0]  ch;
    logic [7:0]  val;
    logic [2:0]  idx;
    logic [16:0] data;
    bit          typed;
    logic [7:0]  want;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = 1'b0;
  logic [7:0]  column_i = '0;
  logic [7:0]  row_i = '0;
  logic [1:0]  channel_i = '0;
  logic [7:0]  pixel_value_i = '0;
  logic        out_valid_o;
  logic [7:0]  equalized_value_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [16:0] cfg_wdata_i = '0;

  clahe_window_equalizer dut (.*);

  // mirror of the block's state
  logic [7:0]  pix_mem [cwe_pkg::StoreDepth];
  bit          pix_set [cwe_pkg::StoreDepth];
  int unsigned bins_r, clip_r, win_r, width_r, height_r;

  logic [7:0] eq_q[$];
  int errors = 0;
  int burst_left = 0;
  int items = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("clahe_window_equalizer: mismatch");
    $finish;
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned sample_at(int x, int y, int ch);
    if (x < 0 || y < 0 || x >= clampu(width_r, 1, cwe_pkg::MaxWidth) ||
        y >= clampu(height_r, 1, cwe_pkg::MaxHeight))
      return 0;
    return pix_mem[(y * cwe_pkg::MaxWidth + x) * cwe_pkg::Channels + ch];
  endfunction

  function automatic logic [7:0] equalize(int col, int row, int ch);
    int unsigned nb, bsz, ws, v, b, centre;
    int          x0, y0;
    int unsigned hist [cwe_pkg::MaxBins];
    longint unsigned n, lim, denom, low_sum, excess, a, num, den, r;
    nb = clampu(bins_r, 1, cwe_pkg::MaxBins);
    bsz = (256 + nb - 1) / nb;
    ws = clampu(win_r, 1, cwe_pkg::MaxWindow);
    x0 = col - int'(ws / 2);
    y0 = row - int'(ws / 2);
    foreach (hist[k]) hist[k] = 0;
    for (int dy = 0; dy < ws; dy++)
      for (int dx = 0; dx < ws; dx++) begin
        v = sample_at(x0 + dx, y0 + dy, ch);
        b = v / bsz;
        if (b >= nb) b = nb - 1;
        hist[b]++;
      end
    centre = sample_at(col, row, ch) / bsz;
    if (centre >= nb) centre = nb - 1;
    n = longint'(ws) * ws;
    lim = longint'(clip_r) * n;
    denom = n << 16;
    low_sum = 0;
    excess = 0;
    for (int k = 0; k < nb; k++) begin
      a = longint'(hist[k]) << 16;
      if (a > lim) begin
        excess += a - lim;
        a = lim;
      end
      if (k <= centre) low_sum += a;
    end
    num = 510 * (nb * low_sum + (centre + 1) * excess) + nb * denom;
    den = 2 * nb * denom;
    r = num / den;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("%0t %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (eq_q.size() == 0) report_mismatch("unexpected result", 8'd0, equalized_value_o);
      else begin
        if (equalized_value_o !== eq_q[0])
          report_mismatch("equalized_value", eq_q[0], equalized_value_o);
        void'(eq_q.pop_front());
      end
    end
  end

  // send one item; the sender runs in bursts separated by random gaps
  task automatic send(cwe_pkg::req_e rt, logic [7:0] c, logic [7:0] r, logic [1:0] ch,
                      logic [7:0] v, bit typed, logic [7:0] want);
    int idx;
    if (burst_left == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    req_type_i = rt;
    column_i = c;
    row_i = r;
    channel_i = ch;
    pixel_value_i = v;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (rt == cwe_pkg::REQ_STORE) begin
      idx = (int'(r) * cwe_pkg::MaxWidth + int'(c)) * cwe_pkg::Channels + int'(ch);
      pix_mem[idx] = v;
      pix_set[idx] = 1'b1;
    end else begin
      eq_q.push_back(typed ? want : equalize(c, r, ch));
    end
  endtask

  // write every unwritten in-image sample of the window before a query
  task automatic fill_window(logic [7:0] c, logic [7:0] r, logic [1:0] ch, bit zeros);
    int ws, x, y;
    ws = clampu(win_r, 1, cwe_pkg::MaxWindow);
    for (int dy = 0; dy < ws; dy++)
      for (int dx = 0; dx < ws; dx++) begin
        x = int'(c) - ws / 2 + dx;
        y = int'(r) - ws / 2 + dy;
        if (x >= 0 && y >= 0 && x < clampu(width_r, 1, cwe_pkg::MaxWidth) &&
            y < clampu(height_r, 1, cwe_pkg::MaxHeight) &&
            !pix_set[(y * cwe_pkg::MaxWidth + x) * cwe_pkg::Channels + ch])
          send(cwe_pkg::REQ_STORE, x[7:0], y[7:0], ch, zeros ? 8'd0 : 8'($urandom),
               1'b0, 8'd0);
      end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (eq_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [16:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    case (idx)
      cwe_pkg::CFG_BIN_COUNT:    bins_r = 32'(data[8:0]);
      cwe_pkg::CFG_CLIP_LEVEL:   clip_r = 32'(data);
      cwe_pkg::CFG_WINDOW_SIZE:  win_r = 32'(data[5:0]);
      cwe_pkg::CFG_IMAGE_WIDTH:  width_r = 32'(data[8:0]);
      cwe_pkg::CFG_IMAGE_HEIGHT: height_r = 32'(data[8:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  step_t dir_tab[] = '{
    '{ACT_STORE, 8'd0,   8'd0,   2'd0, 8'd255, 3'd0, 17'd0, 0, 8'd0},
    '{ACT_STORE, 8'd1,   8'd0,   2'd0, 8'd128, 3'd0, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd0,   8'd0,   2'd0, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd255, 8'd255, 2'd3, 8'd0,   3'd0, 17'd0, 1, 8'd255},
    '{ACT_STORE, 8'd255, 8'd255, 2'd3, 8'd255, 3'd0, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd255, 8'd255, 2'd3, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_CLIP_LEVEL, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd0,   8'd0,   2'd0, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_BIN_COUNT, 17'd1, 0, 8'd0},
    '{ACT_QUERY, 8'd1,   8'd0,   2'd0, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_BIN_COUNT, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd1,   8'd0,   2'd0, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_BIN_COUNT, 17'd511, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_CLIP_LEVEL, 17'h1FFFF, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_WINDOW_SIZE, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd0,   8'd0,   2'd0, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_WINDOW_SIZE, 17'd63, 0, 8'd0},
    '{ACT_QUERY, 8'd100, 8'd100, 2'd2, 8'd0,   3'd0, 17'd0, 1, 8'd255},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_IMAGE_WIDTH, 17'd10, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_IMAGE_HEIGHT, 17'd0, 0, 8'd0},
    '{ACT_QUERY, 8'd20,  8'd0,   2'd0, 8'd0,   3'd0, 17'd0, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_IMAGE_WIDTH, 17'd511, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, cwe_pkg::CFG_IMAGE_HEIGHT, 17'd300, 0, 8'd0},
    '{ACT_CFG,   8'd0, 8'd0, 2'd0, 8'd0, CfgSpare, 17'h15A5A, 0, 8'd0},
    '{ACT_QUERY, 8'd3,   8'd3,   2'd1, 8'd0,   3'd0, 17'd0, 0, 8'd0}
  };

  initial begin
    logic [7:0]  c, r;
    logic [1:0]  ch;
    int          w, h, pick;
    int unsigned bin_pick [11] = '{0, 1, 2, 3, 7, 16, 100, 255, 256, 511, 5};
    bins_r = 256;
    clip_r = 65536;
    win_r = 9;
    width_r = 256;
    height_r = 256;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      case (dir_tab[i].act)
        ACT_CFG:   cfg_write(dir_tab[i].idx, dir_tab[i].data);
        ACT_STORE: send(cwe_pkg::REQ_STORE, dir_tab[i].col, dir_tab[i].row, dir_tab[i].ch,
                        dir_tab[i].val, 1'b0, 8'd0);
        default: begin
          fill_window(dir_tab[i].col, dir_tab[i].row, dir_tab[i].ch, 1'b1);
          send(cwe_pkg::REQ_QUERY, dir_tab[i].col, dir_tab[i].row, dir_tab[i].ch, 8'd0,
               dir_tab[i].typed, dir_tab[i].want);
        end
      endcase
    end

    for (int phase = 0; items < 130; phase++) begin
      cfg_write(cwe_pkg::CFG_BIN_COUNT, (phase % 3 == 2) ? 17'($urandom_range(0, 511))
                                                : 17'(bin_pick[$urandom_range(0, 10)]));
      case ($urandom_range(0, 4))
        0:       cfg_write(cwe_pkg::CFG_CLIP_LEVEL, 17'd0);
        1:       cfg_write(cwe_pkg::CFG_CLIP_LEVEL, 17'($urandom_range(65536, 131071)));
        2:       cfg_write(cwe_pkg::CFG_CLIP_LEVEL, 17'($urandom_range(0, 2000)));
        default: cfg_write(cwe_pkg::CFG_CLIP_LEVEL, 17'($urandom_range(0, 65536)));
      endcase
      cfg_write(cwe_pkg::CFG_WINDOW_SIZE,
                (phase % 7 == 3) ? 17'd63 : 17'($urandom_range(0, 15)));
      cfg_write(cwe_pkg::CFG_IMAGE_WIDTH,
                $urandom_range(0, 1) ? 17'd256 : 17'($urandom_range(0, 511)));
      cfg_write(cwe_pkg::CFG_IMAGE_HEIGHT,
                $urandom_range(0, 1) ? 17'd256 : 17'($urandom_range(0, 511)));
      if (phase % 4 == 1) cfg_write(CfgSpare, 17'($urandom));
      w = clampu(width_r, 1, cwe_pkg::MaxWidth);
      h = clampu(height_r, 1, cwe_pkg::MaxHeight);
      for (int k = 0; k < ((win_r == 63) ? 4 : 16) && items < 130; k++) begin
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, 3) ? 8'($urandom_range(0, w - 1)) : 8'($urandom);
        r = $urandom_range(0, 3) ? 8'($urandom_range(0, h - 1)) : 8'($urandom);
        ch = 2'($urandom);
        if (pick < 70) begin
          fill_window(c, r, ch, 1'b0);
          send(cwe_pkg::REQ_QUERY, c, r, ch, 8'($urandom), 1'b0, 8'd0);
        end else begin
          send(cwe_pkg::REQ_STORE, c, r, ch, 8'($urandom), 1'b0, 8'd0);
        end
        items++;
        // hold the sender until the pipeline is empty once
        if (phase == 2 && k == 5) drain();
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("clahe_window_equalizer: match");
    else $display("clahe_window_equalizer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/cwe_pkg.sv
rtl/core/cwe_ram.sv
rtl/core/cwe_div.sv
rtl/core/clahe_window_equalizer.sv
verif/tb_top.sv
